// ----- design/holonomic_odometry_integrator_top_defines.svh -----
// Assertion macros for the odometry integrator.
`ifndef HOLONOMIC_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH
`define HOLONOMIC_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define HOI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HOI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HOI_ASSERT(label, prop, msg)
`define HOI_ASSERT_RST(label, prop, msg)
`endif

`endif

// ----- design/hoi_pkg.sv -----
package hoi_pkg;

  localparam int SINE_TABLE_BITS    = 12;
  localparam int POSITION_FRAC_BITS = 16;

  localparam int ROM_SIZE    = 1 << SINE_TABLE_BITS;
  localparam int ROM_QUARTER = ROM_SIZE >> 2;

  localparam int FUNC_W     = 1;
  localparam int VEL_W      = 16;
  localparam int YAW_W      = 20;
  localparam int DT_W       = 16;
  localparam int POS_OUT_W  = 32;
  localparam int HEAD_OUT_W = 16;
  localparam int SINE_W     = 16;
  localparam int POS_W      = 48;
  localparam int HEAD_W     = 32;

  localparam logic [FUNC_W-1:0] FUNC_CMD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b1;

  localparam logic [63:0] TWO_PI_Q48 = 64'h0006_487E_D511_0B46;

  typedef logic signed [SINE_W-1:0] sine_tbl_t [ROM_SIZE];

  // round(32767*sin) over the first quadrant, Q31 series
  function automatic logic signed [SINE_W-1:0] quarter_sine(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        scaled;
    x   = (64'(k) * TWO_PI_Q48 + (64'd1 << (SINE_TABLE_BITS + 16)))
          >> (SINE_TABLE_BITS + 17);
    x2  = (x * x) >> 31;
    t   = x;
    sum = $signed(x);
    for (int n = 1; n <= 8; n++) begin
      t = (t * x2) >> 31;
      t = t / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - $signed(t);
      end else begin
        sum = sum + $signed(t);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    scaled = ($unsigned(sum) * 64'd32767 + (64'd1 << 30)) >> 31;
    return SINE_W'(scaled);
  endfunction

  function automatic sine_tbl_t sine_table();
    sine_tbl_t                tbl;
    int unsigned              quad;
    int unsigned              r;
    logic signed [SINE_W-1:0] v;
    for (int unsigned i = 0; i < ROM_SIZE; i++) begin
      quad = i >> (SINE_TABLE_BITS - 2);
      r    = i & (ROM_QUARTER - 1);
      v    = quad[0] ? quarter_sine(ROM_QUARTER - r) : quarter_sine(r);
      tbl[i] = quad[1] ? -v : v;
    end
    return tbl;
  endfunction

endpackage

// ----- design/hoi_in_if.sv -----
interface hoi_in_if;
  import hoi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [YAW_W-1:0] vel_yaw;
  logic [DT_W-1:0]         elapsed;

  modport source (output valid, func, vel_x, vel_y, vel_yaw, elapsed, input ready);
  modport sink (input valid, func, vel_x, vel_y, vel_yaw, elapsed, output ready);
endinterface

// ----- design/hoi_out_if.sv -----
interface hoi_out_if;
  import hoi_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [POS_OUT_W-1:0] pos_x_mm;
  logic signed [POS_OUT_W-1:0] pos_y_mm;
  logic [HEAD_OUT_W-1:0]       heading;
  logic signed [VEL_W-1:0]     echo_vel_x;
  logic signed [VEL_W-1:0]     echo_vel_y;
  logic signed [YAW_W-1:0]     echo_vel_yaw;

  modport source (output valid, pos_x_mm, pos_y_mm, heading, echo_vel_x, echo_vel_y,
                  echo_vel_yaw, input ready);
  modport sink (input valid, pos_x_mm, pos_y_mm, heading, echo_vel_x, echo_vel_y,
                echo_vel_yaw, output ready);
endinterface

// ----- design/holonomic_odometry_integrator_top.sv -----
// Channel   Port    Dir  Transaction
// input     in_if   in   velocity command or integration tick
// result    out_if  out  pose and latched velocities, one per tick
//
// A command loads the three velocities and gives no result.
// A tick is accepted, then runs eight sequencer steps around the one shared
// 34x17 signed multiplier (seven products) and ends in the load step.
// in_if.ready is high only while the sequencer is idle; a waiting result stalls
// only the final load step. Synchronous active-low reset zeroes pose and velocities.
`include "holonomic_odometry_integrator_top_defines.svh"

module holonomic_odometry_integrator_top (
  input  logic      clk,
  input  logic      rst_n,
  hoi_in_if.sink    in_if,
  hoi_out_if.source out_if
);
  import hoi_pkg::*;

  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 17;
  localparam int MUL_W     = MUL_A_W + MUL_B_W;
  localparam int BX_W      = VEL_W + DT_W + 1;
  localparam int ACC_W     = SINE_W + BX_W;
  localparam int ROT_SHIFT = 15 + 16 - POSITION_FRAC_BITS;

  localparam logic [ACC_W:0] RND_BIAS = (ACC_W + 1)'(1) << (ROT_SHIFT - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_A    = 4'd1;
  localparam logic [3:0] ST_B    = 4'd2;
  localparam logic [3:0] ST_C    = 4'd3;
  localparam logic [3:0] ST_D    = 4'd4;
  localparam logic [3:0] ST_E    = 4'd5;
  localparam logic [3:0] ST_F    = 4'd6;
  localparam logic [3:0] ST_G    = 4'd7;
  localparam logic [3:0] ST_H    = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  localparam sine_tbl_t SINE_ROM = sine_table();

  logic [3:0]                  state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]            pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]            pos_y_r, pos_y_nxt;
  logic [HEAD_W-1:0]           heading_r, heading_nxt;
  logic signed [VEL_W-1:0]     vx_r, vx_nxt;
  logic signed [VEL_W-1:0]     vy_r, vy_nxt;
  logic signed [YAW_W-1:0]     yaw_r, yaw_nxt;

  logic [DT_W-1:0]             dt_r;
  logic signed [SINE_W-1:0]    rom_q_r;
  logic signed [SINE_W-1:0]    sin_r;
  logic signed [SINE_W-1:0]    cos_r;
  logic signed [BX_W-1:0]      bx_r;
  logic signed [BX_W-1:0]      by_r;
  logic signed [MUL_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]     acc_r;

  logic signed [POS_OUT_W-1:0] o_pos_x_r;
  logic signed [POS_OUT_W-1:0] o_pos_y_r;
  logic [HEAD_OUT_W-1:0]       o_heading_r;
  logic signed [VEL_W-1:0]     o_vx_r;
  logic signed [VEL_W-1:0]     o_vy_r;
  logic signed [YAW_W-1:0]     o_yaw_r;

  logic [SINE_TABLE_BITS-1:0]  rom_idx;
  logic [SINE_TABLE_BITS-1:0]  rom_addr;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [ACC_W:0]       rnd_sum;
  logic signed [ACC_W:0]       rnd_val;
  logic [POS_W-1:0]            world_step;
  logic                        in_fire;
  logic                        out_free;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  assign rom_idx  = heading_r[HEAD_W-1 -: SINE_TABLE_BITS];
  assign rom_addr = (state_r == ST_A) ? rom_idx + SINE_TABLE_BITS'(ROM_QUARTER) : rom_idx;

  assign rnd_sum    = $signed({acc_r[ACC_W-1], acc_r}) + $signed(RND_BIAS);
  assign rnd_val    = rnd_sum >>> ROT_SHIFT;
  assign world_step = rnd_val[POS_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_A: begin
        mul_a = MUL_A_W'(vx_r);
        mul_b = $signed({1'b0, dt_r});
      end
      ST_B: begin
        mul_a = MUL_A_W'(vy_r);
        mul_b = $signed({1'b0, dt_r});
      end
      ST_C: begin
        mul_a = MUL_A_W'(bx_r);
        mul_b = MUL_B_W'(cos_r);
      end
      ST_D: begin
        mul_a = MUL_A_W'(by_r);
        mul_b = MUL_B_W'(sin_r);
      end
      ST_E: begin
        mul_a = MUL_A_W'(bx_r);
        mul_b = MUL_B_W'(sin_r);
      end
      ST_F: begin
        mul_a = MUL_A_W'(by_r);
        mul_b = MUL_B_W'(cos_r);
      end
      ST_G: begin
        mul_a = MUL_A_W'(yaw_r);
        mul_b = $signed({1'b0, dt_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    heading_nxt   = heading_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    yaw_nxt       = yaw_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_if.func == FUNC_TICK) begin
            state_nxt = ST_A;
          end else begin
            vx_nxt  = in_if.vel_x;
            vy_nxt  = in_if.vel_y;
            yaw_nxt = in_if.vel_yaw;
          end
        end
      end
      ST_A: state_nxt = ST_B;
      ST_B: state_nxt = ST_C;
      ST_C: state_nxt = ST_D;
      ST_D: state_nxt = ST_E;
      ST_E: state_nxt = ST_F;
      ST_F: begin
        pos_x_nxt = pos_x_r + world_step;
        state_nxt = ST_G;
      end
      ST_G: state_nxt = ST_H;
      ST_H: begin
        pos_y_nxt   = pos_y_r + world_step;
        heading_nxt = heading_r + prod_r[HEAD_W-1:0];
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      vx_r        <= '0;
      vy_r        <= '0;
      yaw_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      heading_r   <= heading_nxt;
      vx_r        <= vx_nxt;
      vy_r        <= vy_nxt;
      yaw_r       <= yaw_nxt;
    end
  end

  // sine table read, registered
  always_ff @(posedge clk) begin
    rom_q_r <= SINE_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_fire) begin
      dt_r <= in_if.elapsed;
    end
    case (state_r)
      ST_A: sin_r <= rom_q_r;
      ST_B: begin
        cos_r <= rom_q_r;
        bx_r  <= BX_W'(prod_r);
      end
      ST_C: by_r  <= BX_W'(prod_r);
      ST_D: acc_r <= ACC_W'(prod_r);
      ST_E: acc_r <= acc_r - ACC_W'(prod_r);
      ST_F: acc_r <= ACC_W'(prod_r);
      ST_G: acc_r <= acc_r + ACC_W'(prod_r);
      default: ;
    endcase
    if (state_r == ST_FIN && out_free) begin
      o_pos_x_r   <= pos_x_r[POSITION_FRAC_BITS +: POS_OUT_W];
      o_pos_y_r   <= pos_y_r[POSITION_FRAC_BITS +: POS_OUT_W];
      o_heading_r <= heading_r[HEAD_W-1 -: HEAD_OUT_W];
      o_vx_r      <= vx_r;
      o_vy_r      <= vy_r;
      o_yaw_r     <= yaw_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.pos_x_mm     = o_pos_x_r;
  assign out_if.pos_y_mm     = o_pos_y_r;
  assign out_if.heading      = o_heading_r;
  assign out_if.echo_vel_x   = o_vx_r;
  assign out_if.echo_vel_y   = o_vy_r;
  assign out_if.echo_vel_yaw = o_yaw_r;

  `HOI_ASSERT(a_tick_busy, (in_fire && in_if.func == FUNC_TICK) |=> !in_if.ready, "tick transaction did not start the sequencer")
  `HOI_ASSERT(a_pos_x_hold, (state_r != ST_F) |=> $stable(pos_x_r), "x position moved outside its update step")
  `HOI_ASSERT(a_heading_hold, (state_r != ST_H) |=> $stable(heading_r), "heading moved outside its update step")
  `HOI_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == ST_IDLE && !out_valid_r), "reset left the block busy")

endmodule
